// ===== rtl/tccw_pkg.sv =====
// Package for the text console character writer.
// Holds operation codes, control byte codes, the blank cell and the word layouts.
// No dependencies.
`default_nettype none

package tccw_pkg;

  // Operation codes carried in in_tuser
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Control bytes understood by a put
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LINEFEED  = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;

  // Blank cell: white on black space
  localparam logic [15:0] BLANK_CELL = 16'h0F20;

  // Tab stop spacing (power of two)
  localparam int TAB_STEP = 8;

  // Field widths
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;

  // Word widths on the streams
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

endpackage

`default_nettype wire

// ===== rtl/text_console_character_writer.sv =====
// Text console character writer: screen memory, cursor and a small sequencer.
// Depends on tccw_pkg for codes, the blank cell and word layouts.
//
//   Channel | Ports                          | Carries
//   --------+--------------------------------+------------------------------------
//   input   | in_tvalid/in_tready/in_tdata,  | operation in tuser; char, back,
//           | in_tuser                       | fore, cell index in tdata
//   result  | out_tvalid/out_tready/out_tdata| cursor position, cell data
//
// Put, read and unused operations go from the accept step, which does the cell
// write or memory read and the cursor update, to the finish step, which loads
// the result register. A scrolling put moves each cell below the top row up one
// row, one cell moved per cycle through the memory's one read and one write port,
// then blanks the last row. A clear blanks every cell, one blank write per cycle.
// Reset is synchronous on rst_n; screen contents are not cleared by it.
// in_tready is high only while the sequencer is idle; a result waiting on
// out_tready holds the sequencer in its finish step.
`default_nettype none

module text_console_character_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input words
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [7:0] char_code, [11:8] background, [15:12] foreground, [26:16] cell_index
  input  wire logic [tccw_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] operation
  input  wire logic [tccw_pkg::OP_W-1:0]        in_tuser,
  // result words
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [10:0] cursor_position, [26:11] cell_data
  output logic [tccw_pkg::OUT_DATA_W-1:0]       out_tdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS + tccw_pkg::TAB_STEP);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int XW    = (AW > tccw_pkg::INDEX_W) ? AW : tccw_pkg::INDEX_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCROLL = 2'd1;
  localparam logic [1:0] ST_BLANK  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // Unpack input word
  logic [tccw_pkg::OP_W-1:0]    in_op;
  logic [tccw_pkg::CHAR_W-1:0]  in_char;
  logic [tccw_pkg::COLOR_W-1:0] in_back;
  logic [tccw_pkg::COLOR_W-1:0] in_fore;
  logic [tccw_pkg::INDEX_W-1:0] in_index;

  assign in_op    = in_tuser;
  assign in_char  = in_tdata[7:0];
  assign in_back  = in_tdata[11:8];
  assign in_fore  = in_tdata[15:12];
  assign in_index = in_tdata[26:16];

  // Registers
  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic          mv_r, mv_nxt;
  logic          is_read_r, is_read_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [tccw_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [tccw_pkg::CELL_W-1:0]     rdata_r;

  // Screen memory
  logic [tccw_pkg::CELL_W-1:0] screen_mem [CELLS];

  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [tccw_pkg::CELL_W-1:0] mem_wd;
  logic                        mem_re;
  logic [AW-1:0]               mem_ra;

  // Linear cursor position and read index range check
  logic [XW-1:0] cur_pos;
  logic [XW-1:0] rd_index;
  logic          rd_in_range;

  assign cur_pos     = XW'(row_r) * XW'(COLUMNS) + XW'(col_r);
  assign rd_index    = XW'(in_index);
  assign rd_in_range = (rd_index < XW'(CELLS));

  // Cursor motion for a put
  logic          printable;
  logic [CW-1:0] col_a;
  logic [RW-1:0] row_a;
  logic [CW-1:0] col_b;
  logic [RW-1:0] row_b;

  assign printable = (in_char[7] == 1'b0) && (in_char[6:5] != 2'b00);

  always_comb begin
    col_a = col_r;
    row_a = row_r;
    priority if (in_char == tccw_pkg::CH_BACKSPACE) begin
      if (col_r != '0) col_a = col_r - CW'(1);
    end else if (in_char == tccw_pkg::CH_TAB) begin
      col_a = (col_r + CW'(tccw_pkg::TAB_STEP)) & ~CW'(tccw_pkg::TAB_STEP - 1);
    end else if (in_char == tccw_pkg::CH_RETURN) begin
      col_a = '0;
    end else if (in_char == tccw_pkg::CH_LINEFEED) begin
      col_a = '0;
      row_a = row_r + RW'(1);
    end else if (printable) begin
      col_a = col_r + CW'(1);
    end
    // wrap at the right edge
    col_b = col_a;
    row_b = row_a;
    if (col_a >= CW'(COLUMNS)) begin
      col_b = '0;
      row_b = row_a + RW'(1);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    idx_nxt       = idx_r;
    wa_nxt        = wa_r;
    mv_nxt        = mv_r;
    is_read_nxt   = is_read_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = cur_pos[AW-1:0];
    mem_wd        = {in_back, in_fore, in_char};
    mem_re        = 1'b0;
    mem_ra        = rd_index[AW-1:0];
    in_tready     = (state_r == ST_IDLE);

    // drop a delivered result
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mv_nxt      = 1'b0;
          is_read_nxt = 1'b0;
          state_nxt   = ST_FINISH;
          unique case (in_op)
            tccw_pkg::OP_PUT: begin
              mem_we  = printable;
              col_nxt = col_b;
              row_nxt = row_b;
              if (row_b >= RW'(ROWS)) begin
                row_nxt   = RW'(ROWS - 1);
                idx_nxt   = '0;
                state_nxt = ST_SCROLL;
              end
            end
            tccw_pkg::OP_READ: begin
              mem_re      = rd_in_range;
              is_read_nxt = rd_in_range;
            end
            tccw_pkg::OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              idx_nxt   = '0;
              state_nxt = ST_BLANK;
            end
            default: begin
              // unused code: report the cursor only
            end
          endcase
        end
      end

      ST_SCROLL: begin
        // write the cell read last cycle one row up, read the next one
        mem_we = mv_r;
        mem_wa = wa_r;
        mem_wd = rdata_r;
        mem_re = 1'b1;
        mem_ra = idx_r + AW'(COLUMNS);
        wa_nxt = idx_r;
        mv_nxt = 1'b1;
        idx_nxt = idx_r + AW'(1);
        if (idx_r == AW'(CELLS - COLUMNS - 1)) state_nxt = ST_BLANK;
      end

      ST_BLANK: begin
        mem_we = 1'b1;
        if (mv_r) begin
          // flush the last moved cell
          mem_wa = wa_r;
          mem_wd = rdata_r;
          mv_nxt = 1'b0;
        end else begin
          mem_wa = idx_r;
          mem_wd = tccw_pkg::BLANK_CELL;
          if (idx_r == AW'(CELLS - 1)) begin
            state_nxt = ST_FINISH;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      ST_FINISH: begin
        // load the result once the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = tccw_pkg::OUT_DATA_W'({
                            (is_read_r ? rdata_r : {tccw_pkg::CELL_W{1'b0}}),
                            cur_pos[tccw_pkg::CURSOR_W-1:0]});
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      mv_r        <= mv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    wa_r       <= wa_nxt;
    is_read_r  <= is_read_nxt;
    out_data_r <= out_data_nxt;
  end

  // Screen memory ports
  always_ff @(posedge clk) begin
    if (mem_we) screen_mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= screen_mem[mem_ra];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // Cursor stays on the screen between operations
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r < RW'(ROWS)) && (col_r < CW'(COLUMNS)))
    else $error("cursor left the screen");

  // A pending moved cell exists only during a scroll or its blank pass
  a_move_pending: assert property (@(posedge clk) disable iff (!rst_n)
    mv_r |-> (state_r == ST_SCROLL || state_r == ST_BLANK))
    else $error("moved cell pending outside a scroll");

  // A result appears only after the finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result loaded outside the finish step");
`endif

endmodule

`default_nettype wire

// ===== test/tb_text_console_character_writer.sv =====
// Self-checking testbench for text_console_character_writer: directed and random
// put, read, clear and unused words, checked against an in-bench screen predictor.
// Depends on tccw_pkg and the RTL of text_console_character_writer only.
module tb_text_console_character_writer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int INDEX_MAX  = 2047;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [7:0] CTRL_LAST   = 8'h1F;
  localparam logic [7:0] PRINT_FIRST = 8'h20;
  localparam logic [7:0] PRINT_LAST  = 8'h7F;
  localparam logic [7:0] HIGH_FIRST  = 8'h80;
  localparam logic [7:0] HIGH_LAST   = 8'hFF;

  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [3:0]  back;
    logic [3:0]  fore;
    logic [10:0] idx;
    logic        drain;
  } console_word_t;

  typedef struct packed {
    logic [10:0] cursor;
    logic [15:0] cell_data;
  } console_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tccw_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [tccw_pkg::OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tccw_pkg::OUT_DATA_W-1:0] out_tdata;

  // Screen image and cursor as the block should hold them
  logic [15:0] shadow_cells [CELL_COUNT];
  int cursor_col = 0;
  int cursor_row = 0;

  console_word_t pending_words[$];
  console_result_t expected_results[$];
  console_word_t held_word;

  int sent_words = 0;
  int directed_words = 0;
  int total_words = 0;
  int error_count = 0;
  bit pause_next = 1'b0;

  text_console_character_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one accepted word to the screen image and return the result it gives
  function automatic console_result_t next_console_result(input console_word_t w);
    console_result_t r;
    r.cell_data = '0;
    case (w.op)
      tccw_pkg::OP_PUT: begin
        case (w.ch)
          tccw_pkg::CH_BACKSPACE: begin
            if (cursor_col != 0) cursor_col--;
          end
          tccw_pkg::CH_TAB: begin
            cursor_col = (cursor_col + tccw_pkg::TAB_STEP) & ~(tccw_pkg::TAB_STEP - 1);
          end
          tccw_pkg::CH_RETURN: begin
            cursor_col = 0;
          end
          tccw_pkg::CH_LINEFEED: begin
            cursor_col = 0;
            cursor_row++;
          end
          default: begin
            if (w.ch >= PRINT_FIRST && w.ch <= PRINT_LAST) begin
              shadow_cells[cursor_row * COLUMNS + cursor_col] = {w.back, w.fore, w.ch};
              cursor_col++;
            end
          end
        endcase
        // wrap off the right edge, scroll off the bottom
        if (cursor_col >= COLUMNS) begin
          cursor_col = 0;
          cursor_row++;
        end
        if (cursor_row >= ROWS) begin
          for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
            shadow_cells[i] = shadow_cells[i + COLUMNS];
          for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            shadow_cells[i] = tccw_pkg::BLANK_CELL;
          cursor_row = ROWS - 1;
        end
      end
      tccw_pkg::OP_READ: begin
        if (w.idx < CELL_COUNT) r.cell_data = shadow_cells[w.idx];
      end
      tccw_pkg::OP_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = tccw_pkg::BLANK_CELL;
        cursor_col = 0;
        cursor_row = 0;
      end
      default: ;
    endcase
    r.cursor = 11'((cursor_row * COLUMNS + cursor_col) & INDEX_MAX);
    return r;
  endfunction

  // Queue one word; a pending pause request rides on it
  function automatic void add_word(input logic [1:0] op, input logic [7:0] ch,
                                   input logic [3:0] back, input logic [3:0] fore,
                                   input logic [10:0] idx);
    console_word_t w;
    w.op = op;
    w.ch = ch;
    w.back = back;
    w.fore = fore;
    w.idx = idx;
    w.drain = pause_next;
    pause_next = 1'b0;
    pending_words.push_back(w);
  endfunction

  function automatic void add_put(input logic [7:0] ch, input logic [3:0] back,
                                  input logic [3:0] fore);
    add_word(tccw_pkg::OP_PUT, ch, back, fore, 11'($urandom_range(0, INDEX_MAX)));
  endfunction

  function automatic void add_read(input int idx);
    add_word(tccw_pkg::OP_READ, 8'($urandom), 4'($urandom), 4'($urandom), 11'(idx));
  endfunction

  // Mostly printable text with the control bytes and high bytes mixed in
  function automatic logic [7:0] random_put_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return 8'($urandom_range(PRINT_FIRST, PRINT_LAST));
    if (pick < 84) return tccw_pkg::CH_BACKSPACE;
    if (pick < 88) return tccw_pkg::CH_TAB;
    if (pick < 91) return tccw_pkg::CH_RETURN;
    if (pick < 94) return tccw_pkg::CH_LINEFEED;
    if (pick < 97) return 8'($urandom_range(0, CTRL_LAST));
    return 8'($urandom_range(HIGH_FIRST, HIGH_LAST));
  endfunction

  // Idle percentage for the sender or the receiver in the current phase
  function automatic int idle_pct(input bit sender);
    int phase;
    if (sent_words < directed_words) return 0;
    phase = ((sent_words - directed_words) * 8 / (total_words - directed_words + 1)) % 4;
    case (phase)
      1: return sender ? 51 : 0;
      2: return sender ? 0 : 51;
      3: return 33;
      default: return 0;
    endcase
  endfunction

  function automatic void report_mismatch(input string what, input int want, input int got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endfunction

  // Driver: present queued words, predict each one as it is accepted
  always @(posedge clk) begin
    console_word_t nxt;
    bit slot_free;
    bit idle_now;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(next_console_result(held_word));
        sent_words++;
      end
      slot_free = !in_tvalid || in_tready;
      if (slot_free) begin
        idle_now = ($urandom_range(0, 99) < idle_pct(1'b1));
        if (pending_words.size() != 0 && !idle_now &&
            !(pending_words[0].drain && expected_results.size() != 0)) begin
          nxt = pending_words.pop_front();
          held_word <= nxt;
          in_tdata <= {5'b0, nxt.idx, nxt.fore, nxt.back, nxt.ch};
          in_tuser <= nxt.op;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.cursor = out_tdata[10:0];
        got.cell_data = out_tdata[26:11];
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result word: expected none, got 0x%0h",
                     $time, got);
        end else begin
          want = expected_results.pop_front();
          if (got.cursor != want.cursor)
            report_mismatch("cursor_position", want.cursor, got.cursor);
          if (got.cell_data != want.cell_data)
            report_mismatch("cell_data", want.cell_data, got.cell_data);
        end
      end
      out_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // Stimulus and end of run
  initial begin
    int kind;
    int len;
    int bursts;
    logic [3:0] back;
    logic [3:0] fore;

    // Directed: the screen is cleared first so no read sees an unwritten cell
    add_word(tccw_pkg::OP_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0);
    add_put(8'h41, 4'h0, 4'h0);
    add_put(PRINT_LAST, 4'hF, 4'hF);
    add_put(PRINT_FIRST, 4'hA, 4'h5);
    add_read(0);
    add_read(1);
    add_read(2);
    add_put(tccw_pkg::CH_BACKSPACE, 4'h3, 4'hC);
    add_put(tccw_pkg::CH_TAB, 4'h0, 4'h0);
    add_put(8'h00, 4'hF, 4'hF);
    add_put(HIGH_LAST, 4'h1, 4'h2);
    add_put(HIGH_FIRST, 4'h1, 4'h2);
    add_put(CTRL_LAST, 4'h1, 4'h2);
    add_put(8'h7E, 4'h5, 4'hA);
    add_put(tccw_pkg::CH_RETURN, 4'h0, 4'h0);
    add_put(tccw_pkg::CH_BACKSPACE, 4'h0, 4'h0);
    add_put(tccw_pkg::CH_LINEFEED, 4'h0, 4'h0);
    add_word(OP_UNUSED, HIGH_LAST, 4'hF, 4'hF, 11'(INDEX_MAX));
    add_read(INDEX_MAX);
    add_read(CELL_COUNT);
    add_read(CELL_COUNT - 1);
    add_read(8);
    directed_words = pending_words.size();

    // Random: sessions of text, reads, clears and scroll bursts
    pause_next = 1'b1;
    bursts = 0;
    while (pending_words.size() < directed_words + 1600) begin
      if ($urandom_range(0, 99) < 6) pause_next = 1'b1;
      back = 4'($urandom);
      fore = 4'($urandom);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // line of text with control bytes
        len = $urandom_range(1, 40);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) begin
            back = 4'($urandom);
            fore = 4'($urandom);
          end
          add_put(random_put_byte(), back, fore);
        end
        if ($urandom_range(0, 1) == 0) add_put(tccw_pkg::CH_LINEFEED, back, fore);
      end else if (kind < 55) begin
        // long printable run, which can pass the right edge
        len = $urandom_range(70, 100);
        repeat (len) add_put(8'($urandom_range(PRINT_FIRST, PRINT_LAST)), back, fore);
      end else if (kind < 79) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          if ($urandom_range(0, 99) < 85) add_read($urandom_range(0, CELL_COUNT - 1));
          else add_read($urandom_range(CELL_COUNT, INDEX_MAX));
        end
      end else if (kind < 84) begin
        add_word(OP_UNUSED, 8'($urandom), 4'($urandom), 4'($urandom),
                 11'($urandom_range(0, INDEX_MAX)));
      end else if (kind < 89) begin
        add_word(tccw_pkg::OP_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom),
                 11'($urandom_range(0, INDEX_MAX)));
      end else if (kind < 94 && bursts < 8) begin
        // push the cursor off the bottom, reading now and then from the last two rows
        bursts++;
        len = $urandom_range(20, 28);
        repeat (len) begin
          repeat ($urandom_range(0, 4))
            add_put(8'($urandom_range(PRINT_FIRST, PRINT_LAST)), back, fore);
          add_put(tccw_pkg::CH_LINEFEED, back, fore);
          if ($urandom_range(0, 3) == 0)
            add_read($urandom_range(CELL_COUNT - 2 * COLUMNS, CELL_COUNT - 1));
        end
      end else begin
        // tabs and backspaces, sometimes enough tabs to wrap
        len = $urandom_range(1, 12);
        repeat (len)
          add_put(($urandom_range(0, 3) == 0) ? tccw_pkg::CH_BACKSPACE : tccw_pkg::CH_TAB,
                  back, fore);
      end
    end
    total_words = pending_words.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_text_console_character_writer passed");
    end else begin
      $display("tb_text_console_character_writer failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("tb_text_console_character_writer failed");
    $finish;
  end

endmodule
